### rtl/stms_pkg.sv
// shared types and constants for the sparse tiled mask store
package stms_pkg;

    localparam int TILE_SIDE  = 64;
    localparam int MAX_DIM    = 4096;
    localparam int POOL_TILES = 256;

    localparam int TILES_ACROSS = (MAX_DIM + TILE_SIDE - 1) / TILE_SIDE;
    localparam int DIR_DEPTH    = TILES_ACROSS * TILES_ACROSS;
    localparam int TILE_PIX     = TILE_SIDE * TILE_SIDE;
    localparam int TS_W         = $clog2(TILE_SIDE);
    localparam int TA_W         = $clog2(TILES_ACROSS);
    localparam int DIR_W        = $clog2(DIR_DEPTH);
    localparam int OFF_W        = $clog2(TILE_PIX);
    localparam int SLOT_W       = (POOL_TILES > 1) ? $clog2(POOL_TILES) : 1;
    localparam int CNT_W        = $clog2(POOL_TILES + 1);
    localparam int PIX_W        = SLOT_W + OFF_W;
    localparam int PIX_DEPTH    = POOL_TILES * TILE_PIX;
    localparam int QDEPTH       = 2;

    typedef enum logic [1:0] {
        REQ_READ  = 2'd0,
        REQ_WRITE = 2'd1,
        REQ_CLEAR = 2'd2,
        REQ_FETCH = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_OUTSIDE = 2'd1,
        ST_FULL    = 2'd2
    } stat_t;

    typedef enum logic [1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_FILL   = 2'd2
    } reg_idx_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_LOOK,
        BK_FILL,
        BK_PIX,
        BK_RDWAIT,
        BK_OUT,
        BK_INIT
    } bk_state_t;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [11:0] pixel_x;
        logic [11:0] pixel_y;
        logic [7:0]  write_value;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  read_value;
        logic [1:0]  status;
        logic        dirty_valid;
        logic [11:0] dirty_left;
        logic [11:0] dirty_top;
        logic [11:0] dirty_right;
        logic [11:0] dirty_bottom;
    } out_item_t;

    // classified command handed from front to back
    typedef struct packed {
        logic [1:0]       req_type;
        logic             in_image;
        logic [DIR_W-1:0] dir;
        logic [OFF_W-1:0] off;
        logic [11:0]      pixel_x;
        logic [11:0]      pixel_y;
        logic [7:0]       write_value;
    } cmd_t;

endpackage

### rtl/stms_if.sv
// valid/ready channel interfaces for items, results and configuration
interface stms_in_if;
    logic                 valid;
    logic                 ready;
    stms_pkg::in_item_t   data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface stms_out_if;
    logic                 valid;
    logic                 ready;
    stms_pkg::out_item_t  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface stms_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [12:0] wdata;
    modport source (output valid, output index, output wdata, input ready);
    modport sink   (input valid, input index, input wdata, output ready);
endinterface

### rtl/stms_front.sv
// front end: bounds check and tile address split
module stms_front (
    stms_in_if.sink             in_ch,
    input  logic [12:0]         width_reg,
    input  logic [12:0]         height_reg,
    output logic                cmd_valid,
    output stms_pkg::cmd_t      cmd,
    input  logic                cmd_ready
);
    import stms_pkg::*;

    logic  in_image;
    cmd_t  c;

    always_comb
    begin
        in_image      = ({1'b0, in_ch.data.pixel_x} < width_reg) &&
                        ({1'b0, in_ch.data.pixel_y} < height_reg);
        c.req_type    = in_ch.data.req_type;
        c.in_image    = in_image;
        c.dir         = DIR_W'({in_ch.data.pixel_y[TS_W +: TA_W],
                                in_ch.data.pixel_x[TS_W +: TA_W]});
        c.off         = OFF_W'({in_ch.data.pixel_y[TS_W-1:0],
                                in_ch.data.pixel_x[TS_W-1:0]});
        c.pixel_x     = in_ch.data.pixel_x;
        c.pixel_y     = in_ch.data.pixel_y;
        c.write_value = in_ch.data.write_value;
    end

    assign in_ch.ready = cmd_ready;
    assign cmd_valid   = in_ch.valid;
    assign cmd         = c;
endmodule

### rtl/stms_queue.sv
// two-entry queue between front and back
module stms_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_valid,
    output logic            wr_ready,
    input  stms_pkg::cmd_t  wr_data,
    output logic            rd_valid,
    input  logic            rd_ready,
    output stms_pkg::cmd_t  rd_data
);
    import stms_pkg::*;

    cmd_t       mem_reg [QDEPTH];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign wr_ready = (cnt_reg != 2'(QDEPTH));
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_data  = mem_reg[rp_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push) wp_reg <= ~wp_reg;
            if (pop)  rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end
endmodule

### rtl/stms_back.sv
// back end: directory, pixel memory, init sweep, fill sweep, dirty box
module stms_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    output logic            cmd_ready,
    input  stms_pkg::cmd_t  cmd,
    input  logic [7:0]      fill_reg,
    input  logic            dim_write,
    stms_out_if.source      out_ch
);
    import stms_pkg::*;

    // directory slot store and pixel store
    logic [SLOT_W-1:0] slot_mem [DIR_DEPTH];
    logic [7:0]        pix_mem  [PIX_DEPTH];
    // per-entry copy of the allocated slot, checked against the slot store on lookup
    logic [CNT_W-1:0]  own_mem  [DIR_DEPTH];

    bk_state_t         state_reg, state_next;
    cmd_t              c_reg;
    logic [SLOT_W-1:0] slot_rd_reg;
    logic [CNT_W-1:0]  own_rd_reg;
    logic [7:0]        pix_rd_reg;
    logic [CNT_W-1:0]  next_free_reg;
    logic [OFF_W-1:0]  fill_cnt_reg;
    logic [DIR_W-1:0]  init_cnt_reg;
    logic              box_valid_reg;
    logic [11:0]       bl_reg, bt_reg, br_reg, bb_reg;
    out_item_t         res_reg;
    logic              res_valid_reg;
    logic              filled_reg;

    // tile is present when its stored slot index lies below next free and
    // the owner recorded back at that slot is this entry: owner table keyed by slot
    logic [DIR_W-1:0]  owner_mem [POOL_TILES];
    logic [DIR_W-1:0]  owner_rd_reg;

    logic have, alloc, is_rw;

    assign is_rw = (c_reg.req_type == REQ_READ) || (c_reg.req_type == REQ_WRITE);
    assign have  = (CNT_W'(slot_rd_reg) < next_free_reg) && (owner_rd_reg == c_reg.dir)
                   && (own_rd_reg == CNT_W'(slot_rd_reg));

    assign alloc = (c_reg.req_type == REQ_WRITE) && !have
                   && (c_reg.write_value != fill_reg)
                   && (next_free_reg < CNT_W'(POOL_TILES));

    assign cmd_ready = (state_reg == BK_IDLE) && !res_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_INIT:   if (init_cnt_reg == DIR_W'(DIR_DEPTH - 1)) state_next = BK_IDLE;
            BK_IDLE:   if (cmd_valid && cmd_ready) state_next = BK_LOOK;
            BK_LOOK:
            begin
                if (is_rw && c_reg.in_image)
                    state_next = BK_PIX;
                else
                    state_next = BK_OUT;
            end
            BK_PIX:
            begin
                if (c_reg.req_type == REQ_READ)
                    state_next = have ? BK_RDWAIT : BK_OUT;
                else if (alloc)
                    state_next = BK_FILL;
                else
                    state_next = BK_OUT;
            end
            BK_FILL:   if (fill_cnt_reg == OFF_W'(TILE_PIX - 1)) state_next = BK_OUT;
            BK_RDWAIT: state_next = BK_OUT;
            BK_OUT:    state_next = BK_IDLE;
            default:   state_next = BK_IDLE;
        endcase
    end

    // memories
    logic [SLOT_W-1:0] alloc_slot;
    logic [PIX_W-1:0]  fill_addr;
    assign alloc_slot = SLOT_W'(next_free_reg);
    assign fill_addr  = {slot_rd_reg, fill_cnt_reg};

    always_ff @(posedge clk)
    begin
        if (state_reg == BK_INIT)
        begin
            // directory zeroed once after reset so every lookup reads known data
            slot_mem[init_cnt_reg] <= '0;
            own_mem[init_cnt_reg]  <= '0;
        end
        else if (state_reg == BK_IDLE && cmd_valid)
        begin
            slot_rd_reg <= slot_mem[cmd.dir];
            own_rd_reg  <= own_mem[cmd.dir];
        end
        else if (state_reg == BK_LOOK)
        begin
            owner_rd_reg <= owner_mem[slot_rd_reg];
        end
        else if (state_reg == BK_PIX && alloc)
        begin
            slot_mem[c_reg.dir]   <= alloc_slot;
            own_mem[c_reg.dir]    <= CNT_W'(alloc_slot);
            owner_mem[alloc_slot] <= c_reg.dir;
            slot_rd_reg           <= alloc_slot;
        end
        if (state_reg == BK_PIX && have && c_reg.req_type == REQ_READ)
            pix_rd_reg <= pix_mem[{slot_rd_reg, c_reg.off}];
        if (state_reg == BK_FILL)
            pix_mem[fill_addr] <= (fill_cnt_reg == c_reg.off) ? c_reg.write_value
                                                              : fill_reg;
        else if (state_reg == BK_PIX && have && c_reg.req_type == REQ_WRITE)
            pix_mem[{slot_rd_reg, c_reg.off}] <= c_reg.write_value;
        if (state_reg == BK_IDLE && cmd_valid && cmd_ready)
            c_reg <= cmd;
    end

    // result and box
    out_item_t r;
    logic      grow;
    always_comb
    begin
        r      = '0;
        grow   = 1'b0;
        unique case (c_reg.req_type)
            REQ_READ:
            begin
                r.read_value = fill_reg;
                if (!c_reg.in_image) r.status = ST_OUTSIDE;
                else if (have)       r.read_value = pix_rd_reg;
            end
            REQ_WRITE:
            begin
                if (!c_reg.in_image)
                    r.status = ST_OUTSIDE;
                else if (!have && c_reg.write_value != fill_reg &&
                         next_free_reg >= CNT_W'(POOL_TILES) &&
                         state_reg != BK_FILL && !filled_reg)
                    r.status = ST_FULL;
                else
                    grow = 1'b1;
            end
            REQ_CLEAR: r = '0;
            REQ_FETCH:
            begin
                if (box_valid_reg)
                begin
                    r.dirty_valid  = 1'b1;
                    r.dirty_left   = bl_reg;
                    r.dirty_top    = bt_reg;
                    r.dirty_right  = br_reg;
                    r.dirty_bottom = bb_reg;
                end
            end
            default: r = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_INIT;
            next_free_reg <= '0;
            fill_cnt_reg  <= '0;
            init_cnt_reg  <= '0;
            box_valid_reg <= 1'b0;
            bl_reg <= '0; bt_reg <= '0; br_reg <= '0; bb_reg <= '0;
            res_valid_reg <= 1'b0;
            res_reg       <= '0;
            filled_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == BK_INIT) init_cnt_reg <= init_cnt_reg + 1'b1;
            if (out_ch.ready && res_valid_reg) res_valid_reg <= 1'b0;
            if (state_reg == BK_IDLE) filled_reg <= 1'b0;
            if (state_reg == BK_FILL)
            begin
                fill_cnt_reg <= fill_cnt_reg + 1'b1;
                if (fill_cnt_reg == OFF_W'(TILE_PIX - 1))
                begin
                    next_free_reg <= next_free_reg + 1'b1;
                    filled_reg    <= 1'b1;
                end
            end
            if (state_reg == BK_OUT)
            begin
                res_reg       <= r;
                res_valid_reg <= 1'b1;
                if (c_reg.req_type == REQ_CLEAR || c_reg.req_type == REQ_FETCH)
                begin
                    box_valid_reg <= 1'b0;
                    bl_reg <= '0; bt_reg <= '0; br_reg <= '0; bb_reg <= '0;
                    if (c_reg.req_type == REQ_CLEAR) next_free_reg <= '0;
                end
                else if (grow)
                begin
                    box_valid_reg <= 1'b1;
                    if (!box_valid_reg || c_reg.pixel_x < bl_reg) bl_reg <= c_reg.pixel_x;
                    if (!box_valid_reg || c_reg.pixel_y < bt_reg) bt_reg <= c_reg.pixel_y;
                    if (!box_valid_reg || c_reg.pixel_x > br_reg) br_reg <= c_reg.pixel_x;
                    if (!box_valid_reg || c_reg.pixel_y > bb_reg) bb_reg <= c_reg.pixel_y;
                end
            end
            if (dim_write)
            begin
                next_free_reg <= '0;
                box_valid_reg <= 1'b0;
                bl_reg <= '0; bt_reg <= '0; br_reg <= '0; bb_reg <= '0;
            end
        end
    end

    assign out_ch.valid = res_valid_reg;
    assign out_ch.data  = res_reg;
endmodule

### rtl/sparse_tiled_mask_store_core.sv
// top level of the sparse tiled mask store
//
// channel   dir  payload
// in_ch     in   req_type, pixel_x, pixel_y, write_value
// out_ch    out  read_value, status, dirty_valid, dirty box
// cfg_ch    in   index, wdata (width, height, fill)
//
// path from input transaction to result transaction, by request kind
// read or write in the image: queue, directory read, owner check, pixel port
// read or write outside the image, clear and fetch: queue, directory lookup, result, no pixel access
// write allocating a tile: adds the fill sweep over all TILE_PIX pixels of the new tile
// after reset the back end zeroes all DIR_DEPTH (4096) directory entries first
// a clear needs no sweep, the pool counter marks presence
// a stalled result holds the back end; the queue keeps taking items until both entries are full
module sparse_tiled_mask_store_core (
    input  logic    clk,
    input  logic    rst_n,
    stms_in_if.sink     in_ch,
    stms_out_if.source  out_ch,
    stms_cfg_if.sink    cfg_ch
);
    import stms_pkg::*;

    logic [12:0] width_reg, height_reg;
    logic [7:0]  fill_reg;
    logic        fq_valid, fq_ready, bq_valid, bq_ready, dim_write;
    cmd_t        fq_cmd, bq_cmd;
    logic [12:0] dim_clamped;

    assign cfg_ch.ready = 1'b1;
    // oversized dimensions saturate at the largest image
    assign dim_clamped  = (cfg_ch.wdata > 13'(MAX_DIM)) ? 13'(MAX_DIM) : cfg_ch.wdata;
    assign dim_write    = cfg_ch.valid && (cfg_ch.index == REG_WIDTH ||
                                           cfg_ch.index == REG_HEIGHT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 13'd1024;
            height_reg <= 13'd1024;
            fill_reg   <= 8'd0;
        end
        else if (cfg_ch.valid)
        begin
            unique case (cfg_ch.index)
                REG_WIDTH:  width_reg  <= dim_clamped;
                REG_HEIGHT: height_reg <= dim_clamped;
                REG_FILL:   fill_reg   <= cfg_ch.wdata[7:0];
                default:    ;
            endcase
        end
    end

    stms_front u_front (
        .in_ch, .width_reg, .height_reg,
        .cmd_valid (fq_valid), .cmd (fq_cmd), .cmd_ready (fq_ready)
    );

    stms_queue u_queue (
        .clk, .rst_n,
        .wr_valid (fq_valid), .wr_ready (fq_ready), .wr_data (fq_cmd),
        .rd_valid (bq_valid), .rd_ready (bq_ready), .rd_data (bq_cmd)
    );

    stms_back u_back (
        .clk, .rst_n,
        .cmd_valid (bq_valid), .cmd_ready (bq_ready), .cmd (bq_cmd),
        .fill_reg, .dim_write, .out_ch
    );
endmodule

### rtl/stms_checker.sv
// port-level checker bound to the top level
module stms_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  status,
    input logic        dirty_valid,
    input logic [11:0] dirty_left,
    input logic [11:0] dirty_right
);
    import stms_pkg::*;

    a_stat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status <= 2'(ST_FULL)) else $error("bad status");
    a_box: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && dirty_valid |-> dirty_left <= dirty_right) else $error("box order");
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !dirty_valid |-> dirty_left == 12'd0) else $error("empty box");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid) else $error("drop");
endmodule

bind sparse_tiled_mask_store_core stms_checker u_chk (
    .clk, .rst_n, .out_valid (out_ch.valid), .out_ready (out_ch.ready),
    .status (out_ch.data.status), .dirty_valid (out_ch.data.dirty_valid),
    .dirty_left (out_ch.data.dirty_left), .dirty_right (out_ch.data.dirty_right)
);

### tb/testbench.sv
// self-checking testbench for the sparse tiled mask store core
`timescale 1ns / 100ps

module testbench;
    import stms_pkg::*;

    localparam int IN_W = $bits(in_item_t);

    logic clk;
    logic rst_n;

    stms_in_if  in_ch ();
    stms_out_if out_ch ();
    stms_cfg_if cfg_ch ();

    sparse_tiled_mask_store_core uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg_ch (cfg_ch)
    );

    // mirror of the block state, kept by the mask predictor
    int unsigned img_w;
    int unsigned img_h;
    bit [7:0]    fill;
    bit          tile_here [DIR_DEPTH];
    int unsigned tile_at [DIR_DEPTH];
    bit [7:0]    pix_mem [PIX_DEPTH];
    int unsigned slots_used;
    bit          box_on;
    bit [11:0]   box_l, box_t, box_r, box_b;

    in_item_t    pending_items [$];
    out_item_t   expected_results [$];
    int          mismatches;

    // handshake bookkeeping shared between edges
    bit          in_taken;
    bit          out_got;
    bit          in_burst;
    bit          out_burst;
    int          in_gap;
    int          out_stall;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        // every block input known from time zero
        in_ch.valid   = 1'b0;
        in_ch.data    = '0;
        out_ch.ready  = 1'b0;
        cfg_ch.valid  = 1'b0;
        cfg_ch.index  = REG_WIDTH;
        cfg_ch.wdata  = '0;
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // generous fixed limit: a run with a tile fill behind every write would stay well inside
    initial
    begin
        #300000000;
        $display("Simulation FAILED");
        $finish;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t mismatch on %s: got %0d expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    function automatic void drop_box();
        box_on = 1'b0;
        box_l = '0;
        box_t = '0;
        box_r = '0;
        box_b = '0;
    endfunction

    function automatic void drop_tiles();
        tile_here = '{default: 1'b0};
        slots_used = 0;
        drop_box();
    endfunction

    function automatic void grow_box(input bit [11:0] x, input bit [11:0] y);
        if (!box_on)
        begin
            box_on = 1'b1;
            box_l = x;
            box_t = y;
            box_r = x;
            box_b = y;
        end
        else
        begin
            if (x < box_l) box_l = x;
            if (y < box_t) box_t = y;
            if (x > box_r) box_r = x;
            if (y > box_b) box_b = y;
        end
    endfunction

    function automatic int unsigned clamp_dim(input bit [12:0] v);
        return (v > MAX_DIM) ? MAX_DIM : v;
    endfunction

    function automatic void apply_register(input reg_idx_t idx, input bit [12:0] v);
        case (idx)
            REG_WIDTH:
            begin
                img_w = clamp_dim(v);
                drop_tiles();
            end
            REG_HEIGHT:
            begin
                img_h = clamp_dim(v);
                drop_tiles();
            end
            REG_FILL: fill = v[7:0];
            default: ;
        endcase
    endfunction

    // predicts the result of one request and advances the mirrored state
    function automatic out_item_t predict_mask(input in_item_t it);
        out_item_t   r;
        int unsigned x;
        int unsigned y;
        int unsigned dir;
        int unsigned off;
        int unsigned base;
        bit          ins;
        bit          have;
        r = '0;
        x = it.pixel_x;
        y = it.pixel_y;
        ins = (x < img_w) && (y < img_h);
        dir = (y / TILE_SIDE) * TILES_ACROSS + x / TILE_SIDE;
        off = (y % TILE_SIDE) * TILE_SIDE + x % TILE_SIDE;
        have = ins && tile_here[dir];
        r.status = ST_DONE;
        case (req_t'(it.req_type))
            REQ_READ:
            begin
                if (have)
                    r.read_value = pix_mem[tile_at[dir] * TILE_PIX + off];
                else
                    r.read_value = fill;
                if (!ins)
                    r.status = ST_OUTSIDE;
            end
            REQ_WRITE:
            begin
                if (!ins)
                    r.status = ST_OUTSIDE;
                else if (!have && it.write_value == fill)
                    grow_box(it.pixel_x, it.pixel_y);
                else if (!have && slots_used >= POOL_TILES)
                    r.status = ST_FULL;
                else
                begin
                    if (!have)
                    begin
                        // fresh tile starts out at the fill value
                        tile_at[dir] = slots_used;
                        tile_here[dir] = 1'b1;
                        slots_used++;
                        base = tile_at[dir] * TILE_PIX;
                        for (int i = 0; i < TILE_PIX; i++)
                            pix_mem[base + i] = fill;
                    end
                    pix_mem[tile_at[dir] * TILE_PIX + off] = it.write_value;
                    grow_box(it.pixel_x, it.pixel_y);
                end
            end
            REQ_CLEAR: drop_tiles();
            REQ_FETCH:
            begin
                if (box_on)
                begin
                    r.dirty_valid  = 1'b1;
                    r.dirty_left   = box_l;
                    r.dirty_top    = box_t;
                    r.dirty_right  = box_r;
                    r.dirty_bottom = box_b;
                end
                drop_box();
            end
            default: ;
        endcase
        return r;
    endfunction

    // request driver: changes at the falling edge, holds until the transaction is taken
    always @(negedge clk)
    begin
        if (!rst_n)
            in_ch.valid <= 1'b0;
        else if (!(in_ch.valid && !in_taken))
        begin
            if (in_gap > 0)
            begin
                in_ch.valid <= 1'b0;
                in_gap <= in_gap - 1;
            end
            else if (pending_items.size() > 0)
            begin
                in_ch.data <= pending_items.pop_front();
                in_ch.valid <= 1'b1;
                if ($urandom_range(0, 49) == 0)
                    in_burst <= !in_burst;
                in_gap <= in_burst ? 0 : $urandom_range(0, 19);
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    // request acceptance: the expectation is formed at the accepting edge
    always @(posedge clk)
    begin
        in_taken <= in_ch.valid && in_ch.ready;
        if (rst_n && in_ch.valid && in_ch.ready)
            expected_results.insert(expected_results.size(), predict_mask(in_ch.data));
    end

    // result side back-pressure, redrawn after every result transaction
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
        begin
            if (out_got)
            begin
                if ($urandom_range(0, 49) == 0)
                    out_burst = !out_burst;
                out_stall = out_burst ? 0 : $urandom_range(0, 19);
            end
            if (out_stall > 0)
            begin
                out_ch.ready <= 1'b0;
                out_stall--;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    // result monitor: compares each result with the oldest expectation
    always @(posedge clk)
    begin
        out_item_t got;
        out_item_t want;
        out_got <= out_ch.valid && out_ch.ready;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got = out_ch.data;
            if (expected_results.size() == 0)
                report_mismatch("unexpected result transaction", 1, 0);
            else
            begin
                want = expected_results.pop_front();
                if (got.read_value !== want.read_value)
                    report_mismatch("read_value", got.read_value, want.read_value);
                if (got.status !== want.status)
                    report_mismatch("status", got.status, want.status);
                if (got.dirty_valid !== want.dirty_valid)
                    report_mismatch("dirty_valid", got.dirty_valid, want.dirty_valid);
                if (got.dirty_left !== want.dirty_left)
                    report_mismatch("dirty_left", got.dirty_left, want.dirty_left);
                if (got.dirty_top !== want.dirty_top)
                    report_mismatch("dirty_top", got.dirty_top, want.dirty_top);
                if (got.dirty_right !== want.dirty_right)
                    report_mismatch("dirty_right", got.dirty_right, want.dirty_right);
                if (got.dirty_bottom !== want.dirty_bottom)
                    report_mismatch("dirty_bottom", got.dirty_bottom, want.dirty_bottom);
            end
        end
    end

    // register write, only issued while the block is idle
    task automatic write_register(input reg_idx_t idx, input bit [12:0] v);
        @(negedge clk);
        cfg_ch.index = idx;
        cfg_ch.wdata = v;
        cfg_ch.valid = 1'b1;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        apply_register(idx, v);
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    // waits for every queued request to be taken and every result to arrive
    task automatic drain();
        do
            @(posedge clk);
        while (pending_items.size() > 0 || in_ch.valid || expected_results.size() > 0);
        repeat (10) @(posedge clk);
    endtask

    task automatic queue_item(input req_t rq, input int x, input int y, input int v);
        in_item_t it;
        it.req_type    = rq;
        it.pixel_x     = 12'(x);
        it.pixel_y     = 12'(y);
        it.write_value = 8'(v);
        pending_items.insert(pending_items.size(), it);
    endtask

    // random request: mostly traffic inside a few tiles near the origin
    task automatic queue_random(input int n);
        in_item_t it;
        int       pick;
        repeat (n)
        begin
            pick = $urandom_range(0, 99);
            it.pixel_x = ($urandom_range(0, 9) == 0) ? 12'($urandom)
                                                     : 12'($urandom_range(0, 127));
            it.pixel_y = ($urandom_range(0, 9) == 0) ? 12'($urandom)
                                                     : 12'($urandom_range(0, 127));
            it.write_value = ($urandom_range(0, 3) == 0) ? fill : 8'($urandom);
            if (pick < 45)
                it.req_type = REQ_READ;
            else if (pick < 88)
                it.req_type = REQ_WRITE;
            else if (pick < 91)
                it.req_type = REQ_CLEAR;
            else
                it.req_type = REQ_FETCH;
            if (pick >= 97)
                it = in_item_t'(IN_W'({$urandom, $urandom}));
            pending_items.insert(pending_items.size(), it);
        end
    endtask

    initial
    begin
        img_w = 1024;
        img_h = 1024;
        fill = '0;
        tile_at = '{default: 0};
        drop_tiles();
        mismatches = 0;
        in_taken = 1'b0;
        out_got = 1'b0;
        in_burst = 1'b0;
        out_burst = 1'b0;
        in_gap = 0;
        out_stall = 0;
        wait (rst_n === 1'b1);

        // directed: reset sizes, extremes of every field, each request kind
        queue_item(REQ_FETCH, 0, 0, 0);
        queue_item(REQ_READ, 0, 0, 0);
        queue_item(REQ_WRITE, 0, 0, 0);
        queue_item(REQ_WRITE, 4095, 4095, 255);
        queue_item(REQ_READ, 4095, 4095, 0);
        queue_item(REQ_WRITE, 1023, 1023, 255);
        queue_item(REQ_READ, 1023, 1023, 0);
        queue_item(REQ_READ, 1022, 1023, 0);
        queue_item(REQ_WRITE, 1024, 5, 7);
        queue_item(REQ_WRITE, 5, 1024, 7);
        queue_item(REQ_WRITE, 63, 64, 170);
        queue_item(REQ_READ, 63, 64, 0);
        queue_item(REQ_FETCH, 0, 0, 0);
        queue_item(REQ_FETCH, 0, 0, 0);
        queue_item(REQ_WRITE, 200, 300, 85);
        queue_item(REQ_CLEAR, 4095, 4095, 255);
        queue_item(REQ_READ, 200, 300, 0);
        queue_item(REQ_FETCH, 0, 0, 0);
        drain();

        // full-size image, fill at its top value, oversized width held at the maximum
        write_register(REG_WIDTH, 13'h1fff);
        write_register(REG_HEIGHT, 13'(MAX_DIM));
        write_register(REG_FILL, 13'h0ff);
        queue_item(REQ_WRITE, 4095, 4095, 0);
        queue_item(REQ_READ, 4095, 4095, 0);
        queue_item(REQ_WRITE, 4000, 10, 255);
        queue_item(REQ_READ, 4000, 11, 0);
        queue_item(REQ_FETCH, 0, 0, 0);
        queue_random(250);
        drain();

        // pool exhaustion: one write into each of POOL_TILES + 2 tiles so the pool runs dry
        write_register(REG_WIDTH, 13'(MAX_DIM));
        write_register(REG_FILL, 13'h000);
        for (int i = 0; i <= POOL_TILES + 1; i++)
            queue_item(REQ_WRITE, (i % TILES_ACROSS) * TILE_SIDE + 3,
                       (i / TILES_ACROSS) * TILE_SIDE + 5, 1 + i % 255);
        queue_item(REQ_WRITE, 3, 5, 99);
        queue_item(REQ_READ, 3, 5, 0);
        queue_item(REQ_WRITE, 4095, 4095, 0);
        queue_item(REQ_READ, 4095, 4094, 0);
        queue_item(REQ_FETCH, 0, 0, 0);
        queue_item(REQ_CLEAR, 0, 0, 0);
        queue_item(REQ_WRITE, 4095, 4095, 1);
        queue_item(REQ_READ, 4095, 4095, 0);
        drain();

        // zero width: everything lands outside the image
        write_register(REG_WIDTH, 13'd0);
        write_register(REG_HEIGHT, 13'd300);
        write_register(REG_FILL, 13'h03c);
        queue_item(REQ_READ, 0, 0, 0);
        queue_item(REQ_WRITE, 0, 0, 1);
        queue_item(REQ_FETCH, 0, 0, 0);
        queue_random(60);
        drain();

        // odd small image with a mid-range fill
        write_register(REG_WIDTH, 13'd100);
        write_register(REG_HEIGHT, 13'd70);
        write_register(REG_FILL, 13'h05a);
        queue_random(350);
        drain();

        // one-pixel-wide column spanning the full height
        write_register(REG_WIDTH, 13'd1);
        write_register(REG_HEIGHT, 13'h1000);
        queue_random(150);
        drain();

        // back to the reset shape, random fill
        write_register(REG_WIDTH, 13'd1024);
        write_register(REG_HEIGHT, 13'd0);
        queue_random(40);
        drain();
        write_register(REG_HEIGHT, 13'd1024);
        write_register(REG_FILL, 13'($urandom_range(1, 254)));
        queue_random(160);
        drain();

        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
